### src/rob_pkg.sv
`default_nettype none
package rob_pkg;

   localparam int DEPTH    = 16;
   localparam int TAG_W    = 4;
   localparam int OCC_W    = 5;
   localparam int NUM_REGS = 32;
   localparam int REG_W    = 5;
   localparam int ID_W     = 16;

   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [OCC_W-1:0] occ_type;

   typedef enum logic [1:0] {
      MODE_ALLOC    = 2'd0,
      MODE_COMPLETE = 2'd1,
      MODE_COMMIT   = 2'd2,
      MODE_FLUSH    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_READY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COUNT
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [ID_W-1:0]    instr_id;
      tag_type            tag;
      logic               writes_reg;
      logic [REG_W-1:0]   dest_reg;
      logic               writes_mem;
      logic signed [31:0] value;
      logic [31:0]        mem_addr;
      logic signed [31:0] mem_value;
      logic [ID_W-1:0]    branch_id;
   } req_type;

   typedef struct packed {
      status_type         status;
      tag_type            alloc_tag;
      logic [ID_W-1:0]    committed_id;
      logic               reg_write;
      logic [REG_W-1:0]   reg_index;
      logic signed [31:0] reg_value;
      logic               mem_write;
      logic [31:0]        store_addr;
      logic signed [31:0] store_data;
   } rsp_type;

   typedef struct packed {
      logic            alloc;
      logic            complete;
      logic            commit;
      logic            flush;
      logic            shift;
      tag_type         tail;
      tag_type         head;
      occ_type         occ;
   } cell_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic               ready;
      logic [ID_W-1:0]    id;
      logic               writes_reg;
      logic [REG_W-1:0]   dest;
      logic               writes_mem;
      logic signed [31:0] value;
      logic [31:0]        addr;
      logic signed [31:0] store;
   } cell_view_type;

endpackage
`default_nettype wire

### src/rob_cell.sv
`default_nettype none
module rob_cell
   import rob_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tag_type       cell_idx,
   input  wire cell_ctrl_type ctrl,
   input  wire req_type       req,
   input  wire logic          kill_in,
   output cell_view_type      view,
   output logic              kill_out
);

   logic               busy_ff, busy_in;
   logic               ready_ff, ready_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               wreg_ff, wreg_in;
   logic [REG_W-1:0]   dest_ff, dest_in;
   logic               wmem_ff, wmem_in;
   logic signed [31:0] value_ff;
   logic [31:0]        addr_ff;
   logic signed [31:0] store_ff;
   logic               kill_ff, kill_in_nxt;
   logic               hit_alloc, hit_complete, hit_commit, kill;
   tag_type            ofs;

   always_comb begin
      ofs          = cell_idx - ctrl.head;
      hit_alloc    = ctrl.alloc && (ctrl.tail == cell_idx);
      hit_complete = ctrl.complete && (req.tag == cell_idx) && busy_ff;
      hit_commit   = ctrl.commit && (ctrl.head == cell_idx);
      kill         = ctrl.flush && ({1'b0, ofs} < ctrl.occ) && busy_ff
                     && (id_ff > req.branch_id);
      busy_in  = busy_ff;
      ready_in = ready_ff;
      id_in    = id_ff;
      wreg_in  = wreg_ff;
      dest_in  = dest_ff;
      wmem_in  = wmem_ff;
      if (hit_alloc) begin
         busy_in  = 1'b1;
         ready_in = 1'b0;
         id_in    = req.instr_id;
         wreg_in  = req.writes_reg;
         dest_in  = req.dest_reg;
         wmem_in  = req.writes_mem;
      end
      if (hit_complete) begin
         ready_in = 1'b1;
      end
      if (hit_commit || kill) begin
         busy_in  = 1'b0;
         ready_in = 1'b0;
         id_in    = '0;
         wreg_in  = 1'b0;
         dest_in  = '0;
         wmem_in  = 1'b0;
      end
      kill_in_nxt = kill_ff;
      if (ctrl.flush) begin
         kill_in_nxt = kill;
      end else if (ctrl.shift) begin
         kill_in_nxt = kill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ready_ff <= 1'b0;
         id_ff    <= '0;
         wreg_ff  <= 1'b0;
         dest_ff  <= '0;
         wmem_ff  <= 1'b0;
         kill_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         ready_ff <= ready_in;
         id_ff    <= id_in;
         wreg_ff  <= wreg_in;
         dest_ff  <= dest_in;
         wmem_ff  <= wmem_in;
         kill_ff  <= kill_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_complete) begin
         value_ff <= req.value;
         addr_ff  <= req.mem_addr;
         store_ff <= req.mem_value;
      end
   end

   assign view = '{busy: busy_ff, ready: ready_ff, id: id_ff, writes_reg: wreg_ff,
                   dest: dest_ff, writes_mem: wmem_ff, value: value_ff,
                   addr: addr_ff, store: store_ff};
   assign kill_out = kill_ff;

endmodule
`default_nettype wire

### src/reorder_buffer_unit.sv
// a word is taken at start into req_ff; the EXEC state forms its result, which is registered and strobes on rsp_valid
// a new word is taken only while busy is low; a flush of a non-empty buffer holds busy
// in the COUNT state while the kill marks shift down the cell chain to recount occupancy
// reset: synchronous, clears pointers, occupancy, slot flags and producer table
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none
module reorder_buffer_unit
   import rob_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   state_type        state_ff, state_in;
   req_type          req_ff;
   tag_type          head_ff, head_in, tail_ff, tail_in;
   occ_type          occ_ff, occ_in, killed_ff, killed_in, sum;
   tag_type          idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             pv_ff [NUM_REGS];
   tag_type          pt_ff [NUM_REGS];
   cell_ctrl_type    ctrl;
   cell_view_type    views [DEPTH];
   logic             kills [DEPTH+1];
   cell_view_type    hv;
   logic             full;

   assign kills[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rob_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (TAG_W'(i)),
         .ctrl     (ctrl),
         .req      (req_ff),
         .kill_in  (kills[i+1]),
         .view     (views[i]),
         .kill_out (kills[i])
      );
   end

   assign hv   = views[head_ff];
   assign full = (occ_ff == OCC_W'(DEPTH));
   assign sum  = killed_ff + OCC_W'(kills[0]);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      killed_in    = killed_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ctrl         = '{alloc: 1'b0, complete: 1'b0, commit: 1'b0, flush: 1'b0,
                       shift: 1'b0, tail: tail_ff, head: head_ff, occ: occ_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            unique case (req_ff.mode)
               MODE_ALLOC: begin
                  if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     ctrl.alloc       = 1'b1;
                     tail_in          = tail_ff + 1'b1;
                     occ_in           = occ_ff + 1'b1;
                     rsp_in.alloc_tag = tail_ff;
                  end
               end
               MODE_COMPLETE: begin
                  ctrl.complete = 1'b1;
               end
               MODE_COMMIT: begin
                  if (occ_ff == '0) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else if (!hv.ready) begin
                     rsp_in.status = STATUS_NOT_READY;
                  end else begin
                     ctrl.commit         = 1'b1;
                     head_in             = head_ff + 1'b1;
                     occ_in              = occ_ff - 1'b1;
                     rsp_in.committed_id = hv.id;
                     if (hv.writes_reg) begin
                        rsp_in.reg_write = 1'b1;
                        rsp_in.reg_index = hv.dest;
                        rsp_in.reg_value = hv.value;
                     end
                     if (hv.writes_mem) begin
                        rsp_in.mem_write  = 1'b1;
                        rsp_in.store_addr = hv.addr;
                        rsp_in.store_data = hv.store;
                     end
                  end
               end
               MODE_FLUSH: begin
                  if (occ_ff != '0) begin
                     ctrl.flush = 1'b1;
                     state_in   = ST_COUNT;
                     killed_in  = '0;
                     idx_in     = '0;
                  end
               end
               default: ;
            endcase
         end
         ST_COUNT: begin
            ctrl.shift = 1'b1;
            killed_in  = sum;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == TAG_W'(DEPTH-1)) begin
               occ_in   = occ_ff - sum;
               tail_in  = head_ff + occ_in[TAG_W-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         killed_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         killed_ff    <= killed_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
   end

   // producer table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            pv_ff[r] <= 1'b0;
            pt_ff[r] <= '0;
         end
      end else if (ctrl.alloc && req_ff.writes_reg) begin
         pv_ff[req_ff.dest_reg] <= 1'b1;
         pt_ff[req_ff.dest_reg] <= tail_ff;
      end else if (ctrl.commit && hv.writes_reg && pv_ff[hv.dest]
                   && pt_ff[hv.dest] == head_ff) begin
         pv_ff[hv.dest] <= 1'b0;
         pt_ff[hv.dest] <= '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### src/rob_checker.sv
`default_nettype none
module rob_checker
   import rob_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire req_type req_data,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("result missing two cycles after accept");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.alloc_tag == '0 && rsp_data.committed_id == '0
         && !rsp_data.reg_write && !rsp_data.mem_write)
      else $error("failed word carries data");

   a_reg_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_write |-> rsp_data.reg_index == '0
         && rsp_data.reg_value == '0)
      else $error("register fields set without write");

endmodule

bind reorder_buffer_unit rob_checker u_rob_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_data  (req_data),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
